// ===== hw/rtl/span_alpha_fill_top_defines.svh =====
// Assertion macros for the span fill top level.
`ifndef SPAN_ALPHA_FILL_TOP_DEFINES_SVH
`define SPAN_ALPHA_FILL_TOP_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define SAF_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A trigger that forces a condition to hold in the next cycle.
`define SAF_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== hw/rtl/saf_pkg.sv =====
// Types, constants and pixel helper functions for the span fill block.
`default_nettype none

package saf_pkg;

    localparam int LINE_WIDTH = 1024;
    localparam int IDX_W      = $clog2(LINE_WIDTH);
    localparam int COORD_W    = 17;
    localparam int PIX_W      = 32;

    typedef logic [IDX_W-1:0]          t_idx;
    typedef logic signed [COORD_W-1:0] t_coord;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_SPAN = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    localparam logic [2:0] CFG_FILL_PIXEL    = 3'd0;
    localparam logic [2:0] CFG_FILL_ALPHA    = 3'd1;
    localparam logic [2:0] CFG_CLIP_LEFT     = 3'd2;
    localparam logic [2:0] CFG_CLIP_RIGHT    = 3'd3;
    localparam logic [2:0] CFG_FORCE_OPAQUE  = 3'd4;
    localparam logic [2:0] CFG_CHANNEL_ORDER = 3'd5;

    typedef struct packed {
        logic [PIX_W-1:0] fill_pixel;
        logic [7:0]       alpha;
        logic [7:0]       order;
    } t_blend_cfg;

    typedef struct packed {
        logic valid;
        t_idx idx;
    } t_pix_req;

    typedef struct packed {
        logic             en;
        t_idx             idx;
        logic [PIX_W-1:0] data;
    } t_pix_wr;

    function automatic logic [7:0] get_byte(input logic [PIX_W-1:0] w, input logic [1:0] pos);
        return w[{pos, 3'b000} +: 8];
    endfunction

    function automatic logic [PIX_W-1:0] set_byte(input logic [PIX_W-1:0] w,
                                                  input logic [1:0] pos,
                                                  input logic [7:0] b);
        logic [PIX_W-1:0] r;
        r = w;
        r[{pos, 3'b000} +: 8] = b;
        return r;
    endfunction

    // d*(255-a) + s*a never exceeds 255*255, so 16 bits hold it.
    function automatic logic [15:0] mix_sum(input logic [7:0] d, input logic [7:0] s,
                                            input logic [7:0] a);
        logic [7:0] na;
        na = 8'hFF - a;
        return 16'(d * na) + 16'(s * a);
    endfunction

    // Floor of x/255, exact for every x up to 255*255.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/saf_blend.sv =====
// Four-stage alpha blend pipeline that turns a read pixel into a write-back.
`default_nettype none

module saf_blend
    import saf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_blend_cfg       i_cfg,
    input  wire t_pix_req         i_req,
    input  wire logic [PIX_W-1:0] i_rdata,
    output t_pix_wr               o_wr,
    output logic                  o_busy
);

    logic             r_v0, r_v1, r_v2, r_v3;
    t_idx             r_idx0, r_idx1, r_idx2, r_idx3;
    logic [PIX_W-1:0] r_w1, r_w2, r_w3;
    logic [15:0]      r_sum1, r_sum2, r_sum3;

    logic [1:0] pos_r, pos_g, pos_b, pos_a;
    logic [PIX_W-1:0] n_w1, n_w2, n_w3;
    logic [15:0]      n_sum1, n_sum2, n_sum3;

    assign pos_r = i_cfg.order[1:0];
    assign pos_g = i_cfg.order[3:2];
    assign pos_b = i_cfg.order[5:4];
    assign pos_a = i_cfg.order[7:6];

    // Alpha goes in first; each colour then reads the word as already updated,
    // so repeated positions in the channel order chain correctly.
    always_comb begin
        n_w1   = set_byte(i_rdata, pos_a, 8'hFF);
        n_sum1 = mix_sum(get_byte(n_w1, pos_r), get_byte(i_cfg.fill_pixel, pos_r), i_cfg.alpha);
        n_w2   = set_byte(r_w1, pos_r, div255(r_sum1));
        n_sum2 = mix_sum(get_byte(n_w2, pos_g), get_byte(i_cfg.fill_pixel, pos_g), i_cfg.alpha);
        n_w3   = set_byte(r_w2, pos_g, div255(r_sum2));
        n_sum3 = mix_sum(get_byte(n_w3, pos_b), get_byte(i_cfg.fill_pixel, pos_b), i_cfg.alpha);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= i_req.valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx0 <= i_req.idx;
        r_idx1 <= r_idx0;
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
        r_w1   <= n_w1;
        r_sum1 <= n_sum1;
        r_w2   <= n_w2;
        r_sum2 <= n_sum2;
        r_w3   <= n_w3;
        r_sum3 <= n_sum3;
    end

    assign o_wr.en   = r_v3;
    assign o_wr.idx  = r_idx3;
    assign o_wr.data = set_byte(r_w3, pos_b, div255(r_sum3));
    assign o_busy    = r_v0 | r_v1 | r_v2 | r_v3;

endmodule

`default_nettype wire

// ===== hw/rtl/span_alpha_fill_top.sv =====
// A load writes the line store at its accept edge; a read registers the line store word in r_rdata,
// then moves it to the output register in S_READ. A span passes accept, S_SETUP and, if nonempty, S_SPAN,
// which writes its pixels one at a time, bounded by the single read and write port of the line store;
// blended spans then wait in S_DRAIN until the pipeline is empty. The block takes one transaction at a time.
// Reset clears control state and restores the register defaults; the line store is not cleared.
`default_nettype none
`include "span_alpha_fill_top_defines.svh"

module span_alpha_fill_top
    import saf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_func,
    input  wire logic [9:0]         i_pixel_index,
    input  wire logic [31:0]        i_pixel_in,
    input  wire logic signed [15:0] i_entry_x,
    input  wire logic signed [15:0] i_entry_error,
    input  wire logic               i_entry_leftward,
    input  wire logic signed [15:0] i_exit_x,
    input  wire logic signed [15:0] i_exit_error,
    input  wire logic               i_exit_leftward,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [31:0]             o_pixel_out
);

    typedef enum logic [2:0] {S_IDLE, S_SETUP, S_SPAN, S_DRAIN, S_READ} t_state;

    localparam t_coord RIGHT_MAX = t_coord'(LINE_WIDTH - 1);
    localparam t_coord WIDTH_C   = t_coord'(LINE_WIDTH);

    logic [31:0] r_fill_pixel;
    logic [7:0]  r_fill_alpha;
    logic [9:0]  r_clip_left;
    logic [9:0]  r_clip_right;
    logic        r_force_opaque;
    logic [7:0]  r_channel_order;

    t_state      r_state;
    t_coord      r_start, r_end;
    t_idx        r_idx, r_last;
    logic        r_opaque;
    logic        r_rd_oor;
    logic        r_out_valid;
    logic [31:0] r_out_data;

    logic [PIX_W-1:0] r_mem [LINE_WIDTH];
    logic [PIX_W-1:0] r_rdata;

    logic       in_acc;
    t_coord     pix_ext, n_start, n_end, clip_l, clip_r, right, s_clamp, e_clamp;
    logic       pix_in_range;
    t_idx       pix_addr, rd_addr, wr_addr;
    logic       load_we, fill_we, mem_we;
    logic [PIX_W-1:0] wr_data;
    logic       round_up, round_down;

    t_blend_cfg blend_cfg;
    t_pix_req   blend_req;
    t_pix_wr    blend_wr;
    logic       blend_busy;

    // A read needs the output register free by the time its data arrives.
    assign o_in_stall = (r_state != S_IDLE) ||
                        ((i_func == FUNC_READ) && r_out_valid && i_out_stall);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign pix_ext      = t_coord'({1'b0, i_pixel_index});
    assign pix_in_range = pix_ext < WIDTH_C;
    assign pix_addr     = pix_ext[IDX_W-1:0];

    assign round_up   = i_entry_leftward ? (i_entry_error < 0) : (i_entry_error > 0);
    assign round_down = i_exit_leftward ? (i_exit_error >= 0) : (i_exit_error <= 0);
    assign n_start    = t_coord'(i_entry_x) + (round_up ? t_coord'(1) : t_coord'(0));
    assign n_end      = t_coord'(i_exit_x) - (round_down ? t_coord'(1) : t_coord'(0));

    assign clip_l  = t_coord'({1'b0, r_clip_left});
    assign clip_r  = t_coord'({1'b0, r_clip_right});
    assign right   = (clip_r > RIGHT_MAX) ? RIGHT_MAX : clip_r;
    assign s_clamp = (r_start < clip_l) ? clip_l : r_start;
    assign e_clamp = (r_end > right) ? right : r_end;

    assign blend_cfg.fill_pixel = r_fill_pixel;
    assign blend_cfg.alpha      = r_fill_alpha;
    assign blend_cfg.order      = r_channel_order;
    assign blend_req.valid      = (r_state == S_SPAN) && !r_opaque;
    assign blend_req.idx        = r_idx;

    saf_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (blend_cfg),
        .i_req   (blend_req),
        .i_rdata (r_rdata),
        .o_wr    (blend_wr),
        .o_busy  (blend_busy)
    );

    // Loads, opaque fills and blend write-backs never fall in the same cycle.
    assign load_we = in_acc && (i_func == FUNC_LOAD) && pix_in_range;
    assign fill_we = (r_state == S_SPAN) && r_opaque;
    assign mem_we  = load_we || fill_we || blend_wr.en;
    assign rd_addr = (r_state == S_SPAN) ? r_idx : pix_addr;

    always_comb begin
        if (load_we) begin
            wr_addr = pix_addr;
            wr_data = i_pixel_in;
        end else if (fill_we) begin
            wr_addr = r_idx;
            wr_data = r_fill_pixel;
        end else begin
            wr_addr = blend_wr.idx;
            wr_data = blend_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_pixel    <= 32'd0;
            r_fill_alpha    <= 8'd255;
            r_clip_left     <= 10'd0;
            r_clip_right    <= 10'd1023;
            r_force_opaque  <= 1'b0;
            r_channel_order <= 8'd228;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FILL_PIXEL:    r_fill_pixel    <= i_cfg_data;
                CFG_FILL_ALPHA:    r_fill_alpha    <= i_cfg_data[7:0];
                CFG_CLIP_LEFT:     r_clip_left     <= i_cfg_data[9:0];
                CFG_CLIP_RIGHT:    r_clip_right    <= i_cfg_data[9:0];
                CFG_FORCE_OPAQUE:  r_force_opaque  <= i_cfg_data[0];
                CFG_CHANNEL_ORDER: r_channel_order <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_opaque    <= 1'b0;
            r_rd_oor    <= 1'b0;
            r_idx       <= '0;
            r_last      <= '0;
            r_start     <= '0;
            r_end       <= '0;
            r_out_data  <= '0;
        end else begin
            // The output register is always empty while a read is in S_READ.
            if (!i_out_stall && (r_state != S_READ)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_func == FUNC_SPAN)) begin
                        r_start <= n_start;
                        r_end   <= n_end;
                        r_state <= S_SETUP;
                    end else if (in_acc && (i_func == FUNC_READ)) begin
                        r_rd_oor <= !pix_in_range;
                        r_state  <= S_READ;
                    end
                end
                S_SETUP: begin
                    r_idx    <= s_clamp[IDX_W-1:0];
                    r_last   <= e_clamp[IDX_W-1:0];
                    r_opaque <= (r_fill_alpha == 8'hFF) || r_force_opaque;
                    r_state  <= (s_clamp <= e_clamp) ? S_SPAN : S_IDLE;
                end
                S_SPAN: begin
                    r_idx <= r_idx + t_idx'(1);
                    if (r_idx == r_last) begin
                        r_state <= r_opaque ? S_IDLE : S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!blend_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                S_READ: begin
                    r_out_valid <= 1'b1;
                    r_out_data  <= r_rd_oor ? 32'd0 : r_rdata;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_out_data;

    `SAF_CHECK(a_single_writer, !(load_we && (fill_we || blend_wr.en)), "write port conflict")
    `SAF_CHECK(a_blend_in_span, !blend_wr.en || (r_state == S_SPAN) || (r_state == S_DRAIN), "blend write outside span")
    `SAF_CHECK(a_span_bounds, (r_state != S_SPAN) || (r_idx <= r_last), "span index ran past end")
    `SAF_NEXT(a_read_follows, in_acc && (i_func == FUNC_READ), r_state == S_READ, "read not started")

endmodule

`default_nettype wire

// ===== sim/saf_checker.sv =====
// Checker for the span fill block: tracks configuration, predicts the line store and reads.
module saf_checker
    import saf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_func,
    input  logic [9:0]         i_pixel_index,
    input  logic [31:0]        i_pixel_in,
    input  logic signed [15:0] i_entry_x,
    input  logic signed [15:0] i_entry_error,
    input  logic               i_entry_leftward,
    input  logic signed [15:0] i_exit_x,
    input  logic signed [15:0] i_exit_error,
    input  logic               i_exit_leftward,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [31:0]        i_pixel_out,
    output int                 o_fail_count,
    output int                 o_pending
);

    logic [31:0] fill_word;
    logic [7:0]  opacity;
    logic [9:0]  clip_lo;
    logic [9:0]  clip_hi;
    logic        opaque_force;
    logic [7:0]  byte_order;

    logic [31:0] line_store [LINE_WIDTH];
    logic [31:0] pending_words [$];
    logic [31:0] oldest_word;
    int          mismatches = 0;

    // The alpha byte goes first; each colour byte is read after the earlier writes,
    // so repeated positions in the channel order see bytes already blended.
    function automatic logic [31:0] blend_onto(input logic [31:0] dst);
        logic [31:0] w;
        logic [1:0]  pos;
        int unsigned d;
        int unsigned s;
        int unsigned a;
        w = dst;
        a = opacity;
        w[8*byte_order[7:6] +: 8] = 8'hFF;
        for (int ch = 0; ch < 3; ch++) begin
            pos = byte_order[2*ch +: 2];
            d = w[8*pos +: 8];
            s = fill_word[8*pos +: 8];
            w[8*pos +: 8] = 8'((d * (255 - a) + s * a) / 255);
        end
        return w;
    endfunction

    task automatic paint_span(input logic signed [15:0] ex, input logic signed [15:0] ee,
                              input logic el, input logic signed [15:0] xx,
                              input logic signed [15:0] xe, input logic xl);
        int first;
        int last;
        int right;
        first = int'(ex);
        if (el ? (ee < 0) : (ee > 0)) first++;
        last = int'(xx);
        if (xl ? (xe >= 0) : (xe <= 0)) last--;
        right = (int'(clip_hi) > LINE_WIDTH - 1) ? LINE_WIDTH - 1 : int'(clip_hi);
        if (first < int'(clip_lo)) first = int'(clip_lo);
        if (last > right) last = right;
        for (int i = first; i <= last; i++) begin
            if (opacity == 8'hFF || opaque_force)
                line_store[i] = fill_word;
            else
                line_store[i] = blend_onto(line_store[i]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill_word    = 32'h0;
            opacity      = 8'hFF;
            clip_lo      = 10'd0;
            clip_hi      = 10'd1023;
            opaque_force = 1'b0;
            byte_order   = 8'd228;
            pending_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FILL_PIXEL:    fill_word    = i_cfg_data;
                    CFG_FILL_ALPHA:    opacity      = i_cfg_data[7:0];
                    CFG_CLIP_LEFT:     clip_lo      = i_cfg_data[9:0];
                    CFG_CLIP_RIGHT:    clip_hi      = i_cfg_data[9:0];
                    CFG_FORCE_OPAQUE:  opaque_force = i_cfg_data[0];
                    CFG_CHANNEL_ORDER: byte_order   = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_words.size() == 0) begin
                    $error("pixel_out %h arrived with no read outstanding", i_pixel_out);
                    mismatches++;
                end else begin
                    oldest_word = pending_words.pop_front();
                    if (i_pixel_out !== oldest_word) begin
                        $error("pixel_out mismatch: expected %h, actual %h",
                               oldest_word, i_pixel_out);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_func)
                    FUNC_LOAD: line_store[i_pixel_index] = i_pixel_in;
                    FUNC_SPAN: paint_span(i_entry_x, i_entry_error, i_entry_leftward,
                                          i_exit_x, i_exit_error, i_exit_leftward);
                    FUNC_READ: pending_words.push_back(line_store[i_pixel_index]);
                    default: ;
                endcase
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_words.size();
    end

endmodule

// ===== sim/testbench.sv =====
// Top of the span fill testbench: clock, reset, stimulus, receiver stalls and the verdict.
module testbench;
    import saf_pkg::*;

    localparam logic [1:0] FUNC_UNUSED     = 2'd3;
    localparam int         SETTLE_CYCLES   = LINE_WIDTH + 16;
    localparam int         HOLD_CYCLES     = 1500;
    localparam int         QUIET_LIMIT     = 20000;
    localparam int         RANDOM_PHASES   = 12;
    localparam int         ITEMS_PER_PHASE = 46;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_we         = 1'b0;
    logic [2:0]  i_cfg_index      = 3'd0;
    logic [31:0] i_cfg_data       = 32'h0;
    logic        i_in_valid       = 1'b0;
    logic [1:0]  i_func           = 2'd0;
    logic [9:0]  i_pixel_index    = 10'd0;
    logic [31:0] i_pixel_in       = 32'h0;
    logic [15:0] i_entry_x        = 16'h0;
    logic [15:0] i_entry_error    = 16'h0;
    logic        i_entry_leftward = 1'b0;
    logic [15:0] i_exit_x         = 16'h0;
    logic [15:0] i_exit_error     = 16'h0;
    logic        i_exit_leftward  = 1'b0;
    logic        i_out_stall      = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_pixel_out;

    int pending_reads;
    int fail_total;
    bit hold_req     = 1'b0;
    bit sender_eager = 1'b0;
    int steady_left  = 0;

    span_alpha_fill_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_pixel_index    (i_pixel_index),
        .i_pixel_in       (i_pixel_in),
        .i_entry_x        (i_entry_x),
        .i_entry_error    (i_entry_error),
        .i_entry_leftward (i_entry_leftward),
        .i_exit_x         (i_exit_x),
        .i_exit_error     (i_exit_error),
        .i_exit_leftward  (i_exit_leftward),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_pixel_out      (o_pixel_out)
    );

    saf_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_pixel_index    (i_pixel_index),
        .i_pixel_in       (i_pixel_in),
        .i_entry_x        (i_entry_x),
        .i_entry_error    (i_entry_error),
        .i_entry_leftward (i_entry_leftward),
        .i_exit_x         (i_exit_x),
        .i_exit_error     (i_exit_error),
        .i_exit_leftward  (i_exit_leftward),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_pixel_out      (o_pixel_out),
        .o_fail_count     (fail_total),
        .o_pending        (pending_reads)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Mostly short gaps, some steady stretches with none at all, and a rare long pause.
    function automatic int sender_gap();
        int pick;
        if (steady_left > 0) begin
            steady_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            steady_left = $urandom_range(10, 40);
            return 0;
        end
        if (pick < 50) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 200);
    endfunction

    // Zero sits on the rounding boundary, so it comes up more often than chance gives.
    function automatic logic [15:0] rand_err();
        if ($urandom_range(0, 9) == 0) return 16'h0;
        return 16'($urandom);
    endfunction

    task automatic push(input logic [1:0] f, input logic [9:0] idx, input logic [31:0] pix,
                        input logic [15:0] ex, input logic [15:0] ee, input logic el,
                        input logic [15:0] xx, input logic [15:0] xe, input logic xl);
        int gap;
        gap = sender_eager ? 0 : sender_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_func           <= f;
        i_pixel_index    <= idx;
        i_pixel_in       <= pix;
        i_entry_x        <= ex;
        i_entry_error    <= ee;
        i_entry_leftward <= el;
        i_exit_x         <= xx;
        i_exit_error     <= xe;
        i_exit_leftward  <= xl;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic load_pixel(input logic [9:0] idx, input logic [31:0] pix);
        push(FUNC_LOAD, idx, pix, 16'($urandom), rand_err(), 1'($urandom),
             16'($urandom), rand_err(), 1'($urandom));
    endtask

    task automatic read_pixel(input logic [9:0] idx);
        push(FUNC_READ, idx, $urandom, 16'($urandom), rand_err(), 1'($urandom),
             16'($urandom), rand_err(), 1'($urandom));
    endtask

    task automatic draw(input logic [15:0] ex, input logic [15:0] ee, input logic el,
                        input logic [15:0] xx, input logic [15:0] xe, input logic xl);
        push(FUNC_SPAN, 10'($urandom), $urandom, ex, ee, el, xx, xe, xl);
    endtask

    task automatic random_item();
        int pick;
        int s;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            load_pixel(10'($urandom), $urandom);
        end else if (pick < 65) begin
            read_pixel(10'($urandom));
        end else if (pick < 70) begin
            push(FUNC_UNUSED, 10'($urandom), $urandom, 16'($urandom), rand_err(),
                 1'($urandom), 16'($urandom), rand_err(), 1'($urandom));
        end else if (pick < 72) begin
            draw(16'($urandom), rand_err(), 1'($urandom),
                 16'($urandom), rand_err(), 1'($urandom));
        end else begin
            // Short spans keep the run fast; a few cover the whole line.
            if (pick < 74) begin
                s = -int'($urandom_range(0, 4));
                len = 1100;
            end else begin
                s = int'($urandom_range(0, 1040)) - 8;
                len = int'($urandom_range(0, 26)) - 2;
            end
            draw(16'(s), rand_err(), 1'($urandom), 16'(s + len), rand_err(), 1'($urandom));
        end
    endtask

    task automatic wait_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_reads != 0);
    endtask

    // Loads and spans give no result, so a span may still be running once the reads are in.
    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [31:0] fp, input logic [7:0] al,
                                input logic [9:0] cl, input logic [9:0] cr,
                                input logic fo, input logic [7:0] co);
        logic [2:0]  idx_list [6];
        logic [31:0] val_list [6];
        idx_list = '{CFG_FILL_PIXEL, CFG_FILL_ALPHA, CFG_CLIP_LEFT,
                     CFG_CLIP_RIGHT, CFG_FORCE_OPAQUE, CFG_CHANNEL_ORDER};
        val_list = '{fp, 32'(al), 32'(cl), 32'(cr), 32'(fo), 32'(co)};
        for (int i = 0; i < 6; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx_list[i];
            i_cfg_data  <= val_list[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin : out_stall_gen
        int   run;
        logic level;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                level = 1'b1;
                run = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        level = 1'b0;
                        run = $urandom_range(20, 80);
                    end
                    9: begin
                        level = 1'b1;
                        run = $urandom_range(30, 200);
                    end
                    default: begin
                        level = 1'($urandom);
                        run = $urandom_range(1, 4);
                    end
                endcase
            end
            i_out_stall <= level;
            repeat (run) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [31:0] fp;
        logic [7:0]  al;
        logic [7:0]  co;
        logic [9:0]  cl;
        logic [9:0]  cr;
        logic        fo;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole line once so that no later read or blend sees an unwritten entry.
        draw(16'd0, 16'h0, 1'b0, 16'd1023, 16'h1, 1'b0);
        settle();
        program_regs(32'h1234_5678, 8'hFF, 10'd0, 10'd1023, 1'b0, 8'd228);

        load_pixel(10'd0, 32'hFFFF_FFFF);
        load_pixel(10'd1023, 32'h0);
        load_pixel(10'd512, 32'hA5A5_5A5A);
        read_pixel(10'd0);
        read_pixel(10'd1023);
        read_pixel(10'd512);
        push(FUNC_UNUSED, 10'd512, $urandom, 16'($urandom), rand_err(), 1'b1,
             16'($urandom), rand_err(), 1'b1);
        read_pixel(10'd512);
        // Each direction and error sign on the entry edge; exits also try a zero error.
        draw(16'd10, 16'h0005, 1'b0, 16'd20, 16'h0000, 1'b0);
        draw(16'd30, 16'hFFFF, 1'b1, 16'd40, 16'hFFFF, 1'b1);
        draw(16'd50, 16'h8000, 1'b0, 16'd60, 16'h7FFF, 1'b0);
        draw(16'd70, 16'h7FFF, 1'b1, 16'd80, 16'h0000, 1'b1);
        read_pixel(10'd10);
        read_pixel(10'd11);
        read_pixel(10'd79);
        read_pixel(10'd80);
        draw(16'h8000, 16'h8000, 1'b1, 16'h7FFF, 16'h7FFF, 1'b1);
        read_pixel(10'd1023);
        draw(16'h7FFF, 16'h0, 1'b0, 16'h7FFF, 16'h1, 1'b0);
        draw(16'd100, 16'h0, 1'b0, 16'd50, 16'h1, 1'b0);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            fp = $urandom;
            fo = 1'b0;
            cl = 10'd0;
            cr = 10'd1023;
            case (phase)
                0: begin
                    fp = 32'hFFFF_FFFF;
                    al = 8'h00;
                    co = 8'd228;
                end
                1: begin
                    fp = 32'h0;
                    al = 8'h01;
                    cl = 10'd1023;
                    cr = 10'd1023;
                    co = 8'($urandom);
                end
                2: begin
                    al = 8'hFE;
                    cr = 10'd0;
                    co = 8'h00;
                end
                3: begin
                    al = 8'h80;
                    fo = 1'b1;
                    co = 8'hFF;
                end
                4: begin
                    al = 8'hFF;
                    cl = 10'd600;
                    cr = 10'd300;
                    co = 8'h1B;
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: al = 8'hFF;
                        1: al = 8'h00;
                        default: al = 8'($urandom);
                    endcase
                    fo = ($urandom_range(0, 99) < 15);
                    cl = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, 40)) : 10'($urandom);
                    cr = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(980, 1023))
                                                    : 10'($urandom);
                    co = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'd228;
                end
            endcase
            program_regs(fp, al, cl, cr, fo, co);

            if (phase == 2) begin
                // Receiver holds off while reads keep coming, so the block backs up.
                hold_req = 1'b1;
                while (hold_req) @(posedge i_clk);
                sender_eager = 1'b1;
                repeat (16) read_pixel(10'($urandom));
                sender_eager = 1'b0;
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 6 && n == ITEMS_PER_PHASE / 2)
                    wait_results();
                random_item();
            end
        end

        settle();
        if (fail_total == 0 && pending_reads == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
